/* src/gb2312_text_pretokenizer_top_macros.svh */
// Assertion macros for the GB2312 text pre-tokenizer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef GB2312_TEXT_PRETOKENIZER_TOP_MACROS_SVH
`define GB2312_TEXT_PRETOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gbtok_pkg.sv */
// Shared types and constants of the GB2312 text pre-tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gbtok_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_SEP_LENGTH = 2'd0;
  localparam logic [1:0] REG_SEP_FIRST  = 2'd1;
  localparam logic [1:0] REG_SEP_SECOND = 2'd2;

  // Output slots of one request, emitted lowest first
  localparam int unsigned SLOT_PRE0  = 0;
  localparam int unsigned SLOT_PRE1  = 1;
  localparam int unsigned SLOT_DATA0 = 2;
  localparam int unsigned SLOT_DATA1 = 3;
  localparam int unsigned SLOT_POST0 = 4;
  localparam int unsigned SLOT_POST1 = 5;
  localparam int unsigned NUM_SLOTS  = 6;

  typedef struct packed {
    logic [1:0] sep_length;
    logic [7:0] sep_first;
    logic [7:0] sep_second;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [7:0]           byte0;
    logic [7:0]           byte1;
    logic                 text_end;
  } desc_t;

endpackage

/* src/gbtok_front.sv */
// Front end: accepts text bytes, tracks token state and classifies each byte
// into an output descriptor. Depends on gbtok_pkg.
`timescale 1ns / 1ps

module gbtok_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           text_end_i,
  input  gbtok_pkg::cfg_t  cfg_i,
  input  logic           q_ready_i,
  output logic           push_o,
  output gbtok_pkg::desc_t desc_o
);
  import gbtok_pkg::*;

  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace   = 8'h20;

  function automatic logic is_ascii_alnum(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_ascii_punct(input logic [7:0] b);
    return b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
  endfunction

  function automatic logic is_wide_alnum(input logic [15:0] d);
    return d inside {[16'ha3b0:16'ha3b9], [16'ha3c1:16'ha3da], [16'ha3e1:16'ha3fa]};
  endfunction

  function automatic logic is_wide_symbol(input logic [15:0] d);
    return d inside {[16'ha1a0:16'ha9f0]};
  endfunction

  logic [7:0] lead_q, lead_d;
  logic       lead_valid_q, lead_valid_d;
  logic       ascii_open_q, ascii_open_d;
  logic       wide_open_q, wide_open_d;

  logic        accept;
  logic        pre_sep, post_sep, use0, use1;
  logic [15:0] pair;
  logic        wide_alnum, wide_sym;
  logic        sep_one, sep_two;

  assign accept     = in_valid_i & q_ready_i;
  assign in_ready_o = q_ready_i;
  assign pair       = {lead_q, in_byte_i};
  assign wide_alnum = is_wide_alnum(pair);
  assign wide_sym   = is_wide_symbol(pair);
  assign sep_one    = |cfg_i.sep_length;
  assign sep_two    = cfg_i.sep_length[1];

  always_comb begin
    pre_sep      = 1'b0;
    post_sep     = 1'b0;
    use0         = 1'b0;
    use1         = 1'b0;
    desc_o.byte0 = in_byte_i;
    desc_o.byte1 = in_byte_i;
    lead_d       = lead_q;
    lead_valid_d = lead_valid_q;
    ascii_open_d = ascii_open_q;
    wide_open_d  = wide_open_q;
    if (lead_valid_q) begin
      // Trail byte: the pair goes out whatever its value.
      pre_sep      = wide_open_q & ~wide_alnum;
      use0         = 1'b1;
      use1         = 1'b1;
      desc_o.byte0 = lead_q;
      post_sep     = wide_sym & (~wide_alnum | text_end_i);
      wide_open_d  = wide_sym & wide_alnum & ~text_end_i;
      ascii_open_d = 1'b0;
      lead_valid_d = 1'b0;
    end else if (in_byte_i[7]) begin
      ascii_open_d = 1'b0;
      if (text_end_i) begin
        // A lone lead at the end of a passage goes out by itself.
        pre_sep      = ascii_open_q | wide_open_q;
        use0         = 1'b1;
        wide_open_d  = 1'b0;
        lead_valid_d = 1'b0;
      end else begin
        // A pending full-width separator waits for the trail byte.
        pre_sep      = ascii_open_q;
        lead_d       = in_byte_i;
        lead_valid_d = 1'b1;
      end
    end else begin
      pre_sep     = (ascii_open_q & ~is_ascii_alnum(in_byte_i)) | wide_open_q;
      use0        = 1'b1;
      wide_open_d = 1'b0;
      if (in_byte_i == ChNewline || in_byte_i == ChSpace) begin
        ascii_open_d = 1'b0;
      end else if (is_ascii_punct(in_byte_i)) begin
        post_sep     = 1'b1;
        ascii_open_d = 1'b0;
      end else begin
        post_sep     = text_end_i;
        ascii_open_d = ~text_end_i;
      end
    end
    desc_o.slots             = '0;
    desc_o.slots[SLOT_PRE0]  = pre_sep & sep_one;
    desc_o.slots[SLOT_PRE1]  = pre_sep & sep_two;
    desc_o.slots[SLOT_DATA0] = use0;
    desc_o.slots[SLOT_DATA1] = use1;
    desc_o.slots[SLOT_POST0] = post_sep & sep_one;
    desc_o.slots[SLOT_POST1] = post_sep & sep_two;
    desc_o.text_end          = text_end_i;
  end

  // A request that yields no result is consumed here and never queued.
  assign push_o = accept & (|desc_o.slots);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q       <= '0;
      lead_valid_q <= 1'b0;
      ascii_open_q <= 1'b0;
      wide_open_q  <= 1'b0;
    end else if (accept) begin
      lead_q       <= lead_d;
      lead_valid_q <= lead_valid_d;
      ascii_open_q <= ascii_open_d;
      wide_open_q  <= wide_open_d;
    end
  end

endmodule

/* src/gbtok_queue.sv */
// Short descriptor queue between the front and back ends.
// Depends on gbtok_pkg for the descriptor type.
`timescale 1ns / 1ps

module gbtok_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbtok_pkg::desc_t data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gbtok_pkg::desc_t data_o
);
  import gbtok_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  desc_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* src/gbtok_back.sv */
// Back end: walks the slots of each descriptor and drives one output byte
// per cycle unless the output stalls, through a registered output stage. Depends on gbtok_pkg.
`timescale 1ns / 1ps

module gbtok_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbtok_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  gbtok_pkg::desc_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_item_o,
  output logic           passage_done_o
);
  import gbtok_pkg::*;

  logic [NUM_SLOTS-1:0] slots_q, slots_d;
  logic [7:0]           byte0_q, byte1_q;
  logic                 end_q;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q;
  logic                 out_last_q, out_done_q;

  logic                 have, out_free, advance, work_empty;
  logic [NUM_SLOTS-1:0] low, rest;
  logic [7:0]           sel_byte;

  assign have       = |slots_q;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign advance    = have & out_free;
  assign low        = slots_q & (~slots_q + 1'b1);
  assign rest       = slots_q & ~low;
  assign work_empty = ~have | (advance & ~(|rest));
  assign pop_o      = work_empty & q_valid_i;

  always_comb begin
    case (low)
      NUM_SLOTS'(1) << SLOT_PRE0:  sel_byte = cfg_i.sep_first;
      NUM_SLOTS'(1) << SLOT_PRE1:  sel_byte = cfg_i.sep_second;
      NUM_SLOTS'(1) << SLOT_DATA0: sel_byte = byte0_q;
      NUM_SLOTS'(1) << SLOT_DATA1: sel_byte = byte1_q;
      NUM_SLOTS'(1) << SLOT_POST0: sel_byte = cfg_i.sep_first;
      NUM_SLOTS'(1) << SLOT_POST1: sel_byte = cfg_i.sep_second;
      default:                     sel_byte = byte0_q;
    endcase
  end

  always_comb begin
    if (pop_o) begin
      slots_d = q_data_i.slots;
    end else if (advance) begin
      slots_d = rest;
    end else begin
      slots_d = slots_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slots_q     <= slots_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte0_q <= q_data_i.byte0;
      byte1_q <= q_data_i.byte1;
      end_q   <= q_data_i.text_end;
    end
    if (advance) begin
      out_byte_q <= sel_byte;
      out_last_q <= ~(|rest);
      out_done_q <= ~(|rest) & end_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_item_o = out_last_q;
  assign passage_done_o = out_done_q;

endmodule

/* src/gb2312_text_pretokenizer_top.sv */
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+--------------------------------
// input     | in        | in_valid_i / in_ready_o      | in_byte_i, text_end_i
// output    | out       | out_valid_o / out_ready_i    | out_byte_o, last_of_item_o,
//           |           |                              | passage_done_o
// config    | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// The output stage delivers one byte per cycle while out_ready_i is high; a request
// yields one to six results, and a lead byte with no result is never queued.
// A request accepted by the front passes through the queue, the work register and
// the output register before its first result shows.
// Input requests are taken every cycle while the descriptor queue has room, so the
// front keeps running while the output is stalled. Reset is asynchronous and active
// low; the separator registers return to length 2, '/' and ' '.
`timescale 1ns / 1ps

`include "gb2312_text_pretokenizer_top_macros.svh"

module gb2312_text_pretokenizer_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      text_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      last_of_item_o,
  output logic                      passage_done_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gbtok_pkg::ADDR_W-1:0] paddr,
  input  logic [gbtok_pkg::DATA_W-1:0] pwdata,
  output logic [gbtok_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import gbtok_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_write;
  logic [1:0] reg_idx;

  logic  q_push, q_ready, q_valid, q_pop;
  desc_t q_desc, q_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep_length <= 2'd2;
      cfg_q.sep_first  <= 8'd47;
      cfg_q.sep_second <= 8'd32;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SEP_LENGTH: cfg_q.sep_length <= pwdata[1:0];
        REG_SEP_FIRST:  cfg_q.sep_first  <= pwdata[7:0];
        REG_SEP_SECOND: cfg_q.sep_second <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEP_LENGTH: prdata = {{(DATA_W-2){1'b0}}, cfg_q.sep_length};
      REG_SEP_FIRST:  prdata = {{(DATA_W-8){1'b0}}, cfg_q.sep_first};
      REG_SEP_SECOND: prdata = {{(DATA_W-8){1'b0}}, cfg_q.sep_second};
      default:        prdata = '0;
    endcase
  end

  gbtok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .text_end_i (text_end_i),
    .cfg_i      (cfg_q),
    .q_ready_i  (q_ready),
    .push_o     (q_push),
    .desc_o     (q_desc)
  );

  gbtok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_desc),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  gbtok_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .passage_done_o (passage_done_o)
  );

  `GBTOK_ASSERT_NOW(a_done_on_last, out_valid_o && passage_done_o, last_of_item_o, "passage end flagged on a result that is not the last of its request")
  `GBTOK_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "back end popped an empty queue")
  `GBTOK_ASSERT_NEXT(a_push_visible, q_push && q_ready, q_valid, "queued descriptor not visible to the back end")

endmodule

/* tb/sv/tb_gb2312_text_pretokenizer_top.sv */
// Self-checking testbench for the GB2312 text pre-tokenizer: random text passages in,
// separated byte stream out, compared against a predictor held in a scoreboard class.
// Depends on gbtok_pkg and gb2312_text_pretokenizer_top.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       passage_done;
} tok_result_t;

class token_sep_scoreboard;
  localparam logic [15:0] WIDE_SYM_LO   = 16'hA1A0;
  localparam logic [15:0] WIDE_SYM_HI   = 16'hA9F0;
  localparam logic [15:0] WIDE_DIGIT_LO = 16'hA3B0;
  localparam logic [15:0] WIDE_DIGIT_HI = 16'hA3B9;
  localparam logic [15:0] WIDE_UPPER_LO = 16'hA3C1;
  localparam logic [15:0] WIDE_UPPER_HI = 16'hA3DA;
  localparam logic [15:0] WIDE_LOWER_LO = 16'hA3E1;
  localparam logic [15:0] WIDE_LOWER_HI = 16'hA3FA;
  localparam int unsigned MAX_RESULTS   = 6;

  logic [1:0]  sep_len;
  logic [7:0]  sep_a;
  logic [7:0]  sep_b;
  logic [7:0]  held_lead;
  bit          lead_held;
  bit          ascii_run;
  bit          wide_run;
  logic [7:0]  step_bytes[$];
  tok_result_t awaited[$];
  int unsigned fail_count;

  function new();
    sep_len    = 2'd2;
    sep_a      = 8'h2F;
    sep_b      = 8'h20;
    held_lead  = 8'h00;
    lead_held  = 1'b0;
    ascii_run  = 1'b0;
    wide_run   = 1'b0;
    fail_count = 0;
  endfunction

  function void load_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      gbtok_pkg::REG_SEP_LENGTH: sep_len = value[1:0];
      gbtok_pkg::REG_SEP_FIRST:  sep_a   = value[7:0];
      gbtok_pkg::REG_SEP_SECOND: sep_b   = value[7:0];
      default: ;
    endcase
  endfunction

  // A length of three behaves as two.
  function void add_sep();
    if (sep_len >= 2'd1) step_bytes.push_back(sep_a);
    if (sep_len >= 2'd2) step_bytes.push_back(sep_b);
  endfunction

  function bit is_alnum(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function bit is_punct(logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
  endfunction

  function bit is_wide_alnum(logic [15:0] code);
    return (code >= WIDE_DIGIT_LO && code <= WIDE_DIGIT_HI) ||
           (code >= WIDE_UPPER_LO && code <= WIDE_UPPER_HI) ||
           (code >= WIDE_LOWER_LO && code <= WIDE_LOWER_HI);
  endfunction

  function void take_text_byte(logic [7:0] b, logic fin);
    logic [15:0] code;
    tok_result_t res;
    code = {held_lead, b};
    step_bytes.delete();
    if (lead_held) begin
      lead_held = 1'b0;
      held_lead = 8'h00;
      if (wide_run && !is_wide_alnum(code)) add_sep();
      wide_run = 1'b0;
      step_bytes.push_back(code[15:8]);
      step_bytes.push_back(b);
      if (code >= WIDE_SYM_LO && code <= WIDE_SYM_HI) begin
        if (is_wide_alnum(code)) wide_run = 1'b1;
        else add_sep();
      end
    end else if (b[7]) begin
      if (ascii_run || wide_run) add_sep();
      ascii_run = 1'b0;
      if (fin) begin
        wide_run = 1'b0;
        step_bytes.push_back(b);
      end else begin
        // An open full-width run keeps its separator until the trail byte decides.
        if (wide_run) step_bytes.delete();
        held_lead = b;
        lead_held = 1'b1;
      end
    end else begin
      if ((ascii_run && !is_alnum(b)) || wide_run) add_sep();
      ascii_run = 1'b0;
      wide_run  = 1'b0;
      step_bytes.push_back(b);
      if (b == 8'h0A || b == 8'h20) begin
      end else if (is_punct(b)) begin
        add_sep();
      end else begin
        ascii_run = 1'b1;
      end
    end
    if (fin) begin
      if (ascii_run || wide_run) add_sep();
      ascii_run = 1'b0;
      wide_run  = 1'b0;
      lead_held = 1'b0;
      held_lead = 8'h00;
    end
    while (step_bytes.size() > MAX_RESULTS) void'(step_bytes.pop_back());
    foreach (step_bytes[k]) begin
      res.out_byte     = step_bytes[k];
      res.last_of_item = (k == step_bytes.size() - 1);
      res.passage_done = res.last_of_item && fin;
      awaited.push_back(res);
    end
  endfunction

  task report(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_count++;
  endtask

  task match_output(logic [7:0] ob, logic last, logic done);
    tok_result_t want;
    if (awaited.size() == 0) begin
      report($sformatf("byte %h arrived with nothing awaited", ob));
    end else begin
      want = awaited.pop_front();
      if (ob !== want.out_byte)
        report($sformatf("out_byte %h, awaited %h", ob, want.out_byte));
      if (last !== want.last_of_item)
        report($sformatf("last_of_item %b, awaited %b on byte %h", last,
                         want.last_of_item, want.out_byte));
      if (done !== want.passage_done)
        report($sformatf("passage_done %b, awaited %b on byte %h", done,
                         want.passage_done, want.out_byte));
    end
  endtask
endclass

module tb_gb2312_text_pretokenizer_top;
  import gbtok_pkg::*;

  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int unsigned REST_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 58;
  // {text_end, byte}: ASCII run, punctuation, whitespace, control and DEL, lead after
  // an open run, full-width runs and symbols, out-of-range codes, any trail, lone lead.
  localparam logic [8:0] OPENING [25] = '{
    {1'b0, 8'h41}, {1'b0, 8'h62}, {1'b0, 8'h31}, {1'b0, 8'h2C}, {1'b0, 8'h20},
    {1'b0, 8'h0A}, {1'b0, 8'h00}, {1'b0, 8'h7F}, {1'b0, 8'hB0}, {1'b0, 8'hA1},
    {1'b0, 8'hA3}, {1'b0, 8'hB0}, {1'b0, 8'hA3}, {1'b0, 8'hFA}, {1'b0, 8'hA1},
    {1'b0, 8'hA1}, {1'b0, 8'hA3}, {1'b0, 8'hC1}, {1'b0, 8'h35}, {1'b0, 8'hA9},
    {1'b0, 8'hF1}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b1, 8'h80}, {1'b1, 8'h37}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        in_byte_i;
  logic              text_end_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        out_byte_o;
  logic              last_of_item_o;
  logic              passage_done_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  token_sep_scoreboard sb;
  bit                  calm;
  int unsigned         quiet_cycles;

  gb2312_text_pretokenizer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .text_end_i     (text_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .passage_done_o (passage_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_text_byte(in_byte_i, text_end_i);
      if (out_valid_o && out_ready_i)
        sb.match_output(out_byte_o, last_of_item_o, passage_done_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output back-pressure: random stalls, none in the calm phase.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    text_end_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Leaves the bus idle after each access so that psel is never lowered and raised
  // in the same step.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.load_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper bits of each write carry noise that the block must ignore.
  task automatic set_separators(input logic [1:0] len, input logic [7:0] a,
                                input logic [7:0] b);
    apb_write(REG_SEP_LENGTH, ($urandom() & 32'hFFFF_FFFC) | len);
    apb_write(REG_SEP_FIRST, ($urandom() & 32'hFFFF_FF00) | a);
    apb_write(REG_SEP_SECOND, ($urandom() & 32'hFFFF_FF00) | b);
  endtask

  // A lead byte yields nothing, so the block may still be busy once the queue drains.
  // The wait starts after the next edge so that the final request has been noted.
  task automatic drain_and_rest();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (REST_CYCLES) @(posedge clk_i);
  endtask

  // One passage built from random tokens; text_end marks its final byte.
  task automatic send_passage(output int unsigned sent);
    logic [7:0]  text[$];
    int unsigned len;
    int unsigned n;
    len = $urandom_range(1, 24);
    while (text.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0:       text.push_back(8'(8'h30 + $urandom_range(0, 9)));
              1:       text.push_back(8'(8'h41 + $urandom_range(0, 25)));
              default: text.push_back(8'(8'h61 + $urandom_range(0, 25)));
            endcase
          end
        end
        2: begin
          case ($urandom_range(0, 3))
            0:       text.push_back(8'($urandom_range(33, 47)));
            1:       text.push_back(8'($urandom_range(58, 64)));
            2:       text.push_back(8'($urandom_range(91, 96)));
            default: text.push_back(8'($urandom_range(123, 126)));
          endcase
        end
        3: text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
        4, 5: begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            text.push_back(8'hA3);
            case ($urandom_range(0, 2))
              0:       text.push_back(8'(8'hB0 + $urandom_range(0, 9)));
              1:       text.push_back(8'(8'hC1 + $urandom_range(0, 25)));
              default: text.push_back(8'(8'hE1 + $urandom_range(0, 25)));
            endcase
          end
        end
        6: begin
          text.push_back(8'($urandom_range(8'hA1, 8'hA9)));
          text.push_back(8'($urandom_range(8'hA0, 8'hFE)));
        end
        7: begin
          text.push_back(8'($urandom_range(8'hB0, 8'hF7)));
          text.push_back(8'($urandom_range(8'hA1, 8'hFE)));
        end
        8: text.push_back(8'($urandom_range(0, 255)));
        default: text.push_back(8'($urandom_range(0, 1) ? 8'h7F : $urandom_range(0, 31)));
      endcase
    end
    foreach (text[i]) push_byte(text[i], i == text.size() - 1);
    sent = text.size();
  endtask

  task automatic run_passages(input int unsigned target);
    int unsigned total;
    int unsigned sent;
    total = 0;
    while (total < target) begin
      send_passage(sent);
      total += sent;
    end
    drain_and_rest();
  endtask

  initial begin
    sb          = new();
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    text_end_i  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening requests run on the reset separators.
    foreach (OPENING[i]) push_byte(OPENING[i][7:0], OPENING[i][8]);
    drain_and_rest();

    set_separators(2'd0, 8'h00, 8'hFF);
    run_passages(PHASE_ITEMS);
    set_separators(2'd1, 8'hFF, 8'h00);
    run_passages(PHASE_ITEMS);
    set_separators(2'd3, 8'h7C, 8'h0A);
    run_passages(PHASE_ITEMS);
    // A write beyond the last register must leave every separator setting intact.
    set_separators(2'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    apb_write(REG_UNUSED, $urandom());
    run_passages(PHASE_ITEMS);
    set_separators(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    run_passages(PHASE_ITEMS);
    calm = 1'b1;
    set_separators(2'd2, 8'h2F, 8'hFF);
    run_passages(PHASE_ITEMS);

    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/gbtok_pkg.sv
src/gbtok_front.sv
src/gbtok_queue.sv
src/gbtok_back.sv
src/gb2312_text_pretokenizer_top.sv
tb/sv/tb_gb2312_text_pretokenizer_top.sv
